@@ rtl/fcsg_pkg.sv @@
`default_nettype none
package fcsg_pkg;

  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 16;
  localparam int RADIUS_W   = 4;
  localparam int LEN_W      = 5;
  localparam int SCREEN_W   = 12;
  localparam int LIM_W      = 8;
  localparam int SUMSQ_W    = 9;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int DEF_MAX_RADIUS    = 15;
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 480;

  // Register select taken from the word address bit
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Unclamped span handed from the sequencer to the clamp unit
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   len;
  } span_req_t;

  // Last row index: r*707/1000 + 1, as a table over all radii
  function automatic logic [RADIUS_W-1:0] imax_of(input logic [RADIUS_W-1:0] r);
    logic [RADIUS_W-1:0] v;
    case (r)
      4'd0:    v = 4'd1;
      4'd1:    v = 4'd1;
      4'd2:    v = 4'd2;
      4'd3:    v = 4'd3;
      4'd4:    v = 4'd3;
      4'd5:    v = 4'd4;
      4'd6:    v = 4'd5;
      4'd7:    v = 4'd5;
      4'd8:    v = 4'd6;
      4'd9:    v = 4'd7;
      4'd10:   v = 4'd8;
      4'd11:   v = 4'd8;
      4'd12:   v = 4'd9;
      4'd13:   v = 4'd10;
      4'd14:   v = 4'd10;
      default: v = 4'd11;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fcsg_clamp.sv @@
`default_nettype none
module fcsg_clamp
  import fcsg_pkg::*;
(
  input  wire span_req_t          req,
  input  wire [SCREEN_W-1:0]      screen_width,
  input  wire [SCREEN_W-1:0]      screen_height,
  output logic [COORD_W-1:0]      span_x,
  output logic [COORD_W-1:0]      span_y
);

  logic [COORD_W:0]   right_end;
  logic [COORD_W-1:0] width_ext;
  logic [COORD_W-1:0] height_ext;

  assign width_ext  = {{(COORD_W-SCREEN_W){1'b0}}, screen_width};
  assign height_ext = {{(COORD_W-SCREEN_W){1'b0}}, screen_height};
  assign right_end  = {1'b0, req.x} + {{(COORD_W+1-LEN_W){1'b0}}, req.len} - (COORD_W+1)'(1);

  // Pull the start back inside the right edge and the row inside the bottom edge; wrap as the coordinates do
  always_comb begin
    if (right_end >= {1'b0, width_ext}) begin
      span_x = width_ext - {{(COORD_W-LEN_W){1'b0}}, req.len} - COORD_W'(1);
    end else begin
      span_x = req.x;
    end
    if (req.y >= height_ext) begin
      span_y = height_ext - COORD_W'(1);
    end else begin
      span_y = req.y;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fcsg_seq.sv @@
`default_nettype none
module fcsg_seq
  import fcsg_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire [COORD_W-1:0]    center_x,
  input  wire [COORD_W-1:0]    center_y,
  input  wire [RADIUS_W-1:0]   radius,
  input  wire [COLOR_W-1:0]    color,
  output logic                 busy,
  output span_req_t            req,
  output logic                 done,
  output logic [COLOR_W-1:0]   color_out
);

  typedef enum logic [2:0] {
    S_IDLE, S_CENTER, S_TEST, S_OUT_P, S_OUT_M, S_IN_P, S_IN_M, S_FLUSH
  } state_t;

  state_t               state_r, state_nxt;
  logic [COORD_W-1:0]   cx_r, cx_nxt;
  logic [COORD_W-1:0]   cy_r, cy_nxt;
  logic [COLOR_W-1:0]   color_r, color_nxt;
  logic [RADIUS_W-1:0]  r_r, r_nxt;
  logic [RADIUS_W-1:0]  imax_r, imax_nxt;
  logic [LIM_W-1:0]     lim_r, lim_nxt;
  logic [RADIUS_W-1:0]  x_r, x_nxt;
  logic [RADIUS_W-1:0]  i_r, i_nxt;

  logic [RADIUS_W-1:0]  r_sat;
  logic [LIM_W-1:0]     r_sq;
  logic [LIM_W-1:0]     i_sq;
  logic [LIM_W-1:0]     x_sq;
  logic [SUMSQ_W-1:0]   sum_sq;
  logic [RADIUS_W-1:0]  i_dec;
  logic [COORD_W-1:0]   x_ext;
  logic [COORD_W-1:0]   i_ext;

  assign r_sat  = (radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius;
  assign r_sq   = {{(LIM_W-RADIUS_W){1'b0}}, r_sat} * {{(LIM_W-RADIUS_W){1'b0}}, r_sat};
  assign i_sq   = {{(LIM_W-RADIUS_W){1'b0}}, i_r} * {{(LIM_W-RADIUS_W){1'b0}}, i_r};
  assign x_sq   = {{(LIM_W-RADIUS_W){1'b0}}, x_r} * {{(LIM_W-RADIUS_W){1'b0}}, x_r};
  assign sum_sq = {1'b0, i_sq} + {1'b0, x_sq};
  assign i_dec  = i_r - RADIUS_W'(1);
  assign x_ext  = {{(COORD_W-RADIUS_W){1'b0}}, x_r};
  assign i_ext  = {{(COORD_W-RADIUS_W){1'b0}}, i_r};

  assign busy      = (state_r != S_IDLE);
  assign done      = (state_r == S_FLUSH);
  assign color_out = color_r;

  // Raw span for the current step
  always_comb begin
    req = '0;
    unique case (state_r)
      S_CENTER: begin
        req.valid = 1'b1;
        req.x     = cx_r - {{(COORD_W-RADIUS_W){1'b0}}, r_r};
        req.y     = cy_r;
        req.len   = {r_r, 1'b0};
      end
      S_OUT_P, S_OUT_M: begin
        req.valid = 1'b1;
        req.x     = cx_r - i_ext + COORD_W'(1);
        req.y     = (state_r == S_OUT_P) ? (cy_r + x_ext) : (cy_r - x_ext);
        req.len   = {i_dec, 1'b0};
      end
      S_IN_P, S_IN_M: begin
        req.valid = 1'b1;
        req.x     = cx_r - x_ext;
        req.y     = (state_r == S_IN_P) ? (cy_r + i_ext) : (cy_r - i_ext);
        req.len   = {x_r, 1'b0};
      end
      default: req = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    color_nxt = color_r;
    r_nxt     = r_r;
    imax_nxt  = imax_r;
    lim_nxt   = lim_r;
    x_nxt     = x_r;
    i_nxt     = i_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cx_nxt    = center_x;
          cy_nxt    = center_y;
          color_nxt = color;
          r_nxt     = r_sat;
          imax_nxt  = imax_of(r_sat);
          lim_nxt   = r_sq + LIM_W'(r_sat >> 1);
          x_nxt     = r_sat;
          i_nxt     = RADIUS_W'(1);
          if (r_sat != '0) begin
            state_nxt = S_CENTER;
          end
        end
      end
      S_CENTER: state_nxt = S_TEST;
      S_TEST: begin
        if (sum_sq > {1'b0, lim_r}) begin
          if (x_r > imax_r) begin
            state_nxt = S_OUT_P;
          end else begin
            if (x_r != '0) begin
              x_nxt = x_r - RADIUS_W'(1);
            end
            state_nxt = S_IN_P;
          end
        end else begin
          state_nxt = S_IN_P;
        end
      end
      S_OUT_P: state_nxt = S_OUT_M;
      S_OUT_M: begin
        x_nxt     = x_r - RADIUS_W'(1);
        state_nxt = S_IN_P;
      end
      S_IN_P: state_nxt = S_IN_M;
      S_IN_M: begin
        if (i_r == imax_r) begin
          state_nxt = S_FLUSH;
        end else begin
          i_nxt     = i_r + RADIUS_W'(1);
          state_nxt = S_TEST;
        end
      end
      S_FLUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    color_r <= color_nxt;
    r_r     <= r_nxt;
    imax_r  <= imax_nxt;
    lim_r   <= lim_nxt;
    x_r     <= x_nxt;
    i_r     <= i_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/filled_circle_span_generator_top.sv @@
`default_nettype none
// Filled circle span generator. Pulse start with a circle command (centre,
// radius, colour) while busy is low; the block then streams the horizontal
// spans that fill the circle, one per out_strobe pulse, with out_last_span
// set on the final span. The receiver cannot stall: every span is on the
// out_ ports for exactly one cycle. Busy stays high while the sequencer
// emits the centre span and the rows i = 1..imax, imax = r*707/1000 + 1:
// two inner and, where due, two outer spans per row. Each span waits in a
// single holding stage until a later live span or the end of the command
// frees it, then passes the output register, so the last appears in the
// cycle busy falls. A radius of zero is accepted and gives no spans.
// Screen size registers sit at byte addresses 0 (width) and 4 (height).
module filled_circle_span_generator_top
  import fcsg_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // command channel
  input  wire                    start,
  output logic                   busy,
  input  wire [COORD_W-1:0]      in_center_x,
  input  wire [COORD_W-1:0]      in_center_y,
  input  wire [RADIUS_W-1:0]     in_radius,
  input  wire [COLOR_W-1:0]      in_color,
  // span channel
  output logic                   out_strobe,
  output logic [COORD_W-1:0]     out_span_x,
  output logic [COORD_W-1:0]     out_span_y,
  output logic [LEN_W-1:0]       out_span_length,
  output logic [COLOR_W-1:0]     out_span_color,
  output logic                   out_last_span,
  // configuration port
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [APB_ADDR_W-1:0]   paddr,
  input  wire [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [SCREEN_W-1:0] cfg_width_r;
  logic [SCREEN_W-1:0] cfg_height_r;
  logic                cfg_wr;

  span_req_t           req;
  logic                seq_done;
  logic [COLOR_W-1:0]  seq_color;
  logic [COORD_W-1:0]  clamp_x;
  logic [COORD_W-1:0]  clamp_y;
  logic                req_live;

  // holding stage: one span kept back until we know whether it is the last
  logic                pend_r;
  logic [COORD_W-1:0]  pend_x_r;
  logic [COORD_W-1:0]  pend_y_r;
  logic [LEN_W-1:0]    pend_len_r;

  logic                out_strobe_r, out_strobe_nxt;
  logic                out_last_r, out_last_nxt;
  logic [COORD_W-1:0]  out_x_r;
  logic [COORD_W-1:0]  out_y_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [COLOR_W-1:0]  out_color_r;

  // ---------------------------------------------------------------------
  // Configuration registers: the word bit of paddr selects the register,
  // byte offsets inside a word are ignored.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= SCREEN_W'(DEF_SCREEN_WIDTH);
      cfg_height_r <= SCREEN_W'(DEF_SCREEN_HEIGHT);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SCREEN_WIDTH:  cfg_width_r  <= pwdata[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: cfg_height_r <= pwdata[SCREEN_W-1:0];
        default:           cfg_width_r  <= cfg_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = {{(APB_DATA_W-SCREEN_W){1'b0}}, cfg_width_r};
      REG_SCREEN_HEIGHT: prdata = {{(APB_DATA_W-SCREEN_W){1'b0}}, cfg_height_r};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Row sequencer and the shared clamp unit every span passes through
  // ---------------------------------------------------------------------
  fcsg_seq #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .radius    (in_radius),
    .color     (in_color),
    .busy      (busy),
    .req       (req),
    .done      (seq_done),
    .color_out (seq_color)
  );

  fcsg_clamp u_clamp (
    .req           (req),
    .screen_width  (cfg_width_r),
    .screen_height (cfg_height_r),
    .span_x        (clamp_x),
    .span_y        (clamp_y)
  );

  // Drop zero-length spans before they reach the holding stage
  assign req_live = req.valid && (req.len != '0);

  // ---------------------------------------------------------------------
  // Holding stage and output register. A new live span pushes the held
  // one out with last clear; the end of the command flushes it with last
  // set. Nothing is held across commands.
  // ---------------------------------------------------------------------
  always_comb begin
    out_strobe_nxt = 1'b0;
    out_last_nxt   = 1'b0;
    if (req_live && pend_r) begin
      out_strobe_nxt = 1'b1;
    end else if (seq_done && pend_r) begin
      out_strobe_nxt = 1'b1;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      out_last_r   <= out_last_nxt;
      if (req_live) begin
        pend_r <= 1'b1;
      end else if (seq_done) begin
        pend_r <= 1'b0;
      end
    end
    if (req_live) begin
      pend_x_r   <= clamp_x;
      pend_y_r   <= clamp_y;
      pend_len_r <= req.len;
    end
    if (out_strobe_nxt) begin
      out_x_r     <= pend_x_r;
      out_y_r     <= pend_y_r;
      out_len_r   <= pend_len_r;
      out_color_r <= seq_color;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_last_span   = out_last_r;
  assign out_span_x      = out_x_r;
  assign out_span_y      = out_y_r;
  assign out_span_length = out_len_r;
  assign out_span_color  = out_color_r;

endmodule
`default_nettype wire

@@ rtl/fcsg_checker.sv @@
`default_nettype none
module fcsg_checker
  import fcsg_pkg::*;
(
  input wire                clk,
  input wire                rst_n,
  input wire                start,
  input wire                busy,
  input wire [RADIUS_W-1:0] in_radius,
  input wire                out_strobe,
  input wire [LEN_W-1:0]    out_span_length,
  input wire                out_last_span
);

  // last flag only rides on a delivered span
  a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_span |-> out_strobe)
    else $error("last span flag without strobe");

  // the closing span leaves as the block goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_span) |-> !busy)
    else $error("busy still high on final span");

  // a command with a non-zero radius keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_radius != '0)) |=> busy)
    else $error("accepted command did not raise busy");

  // spans are symmetric about the centre: even and never empty
  a_len_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_span_length != '0) && !out_span_length[0]))
    else $error("span length zero or odd");

endmodule

bind filled_circle_span_generator_top fcsg_checker u_fcsg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_radius       (in_radius),
  .out_strobe      (out_strobe),
  .out_span_length (out_span_length),
  .out_last_span   (out_last_span)
);
`default_nettype wire

@@ verif/circle_span_checker.sv @@
module circle_span_checker
  import fcsg_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire                   busy,
  input  wire [COORD_W-1:0]     in_center_x,
  input  wire [COORD_W-1:0]     in_center_y,
  input  wire [RADIUS_W-1:0]    in_radius,
  input  wire [COLOR_W-1:0]     in_color,
  input  wire                   out_strobe,
  input  wire [COORD_W-1:0]     out_span_x,
  input  wire [COORD_W-1:0]     out_span_y,
  input  wire [LEN_W-1:0]       out_span_length,
  input  wire [COLOR_W-1:0]     out_span_color,
  input  wire                   out_last_span,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire                   pready,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  output int                    fail_count,
  output int                    spans_pending
);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] color;
    logic               last;
  } span_t;

  span_t               expected_spans[$];
  span_t               held_span;
  bit                  have_held;
  logic [SCREEN_W-1:0] width_reg;
  logic [SCREEN_W-1:0] height_reg;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < 40)
      $display("%0t: span %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Clamp one span to the screen; hold it back one step so the last can be tagged
  function automatic void queue_span(input int unsigned sx, input int unsigned sy,
                                     input int unsigned len, input int unsigned color);
    int unsigned w;
    int unsigned h;
    w   = width_reg;
    h   = height_reg;
    sx  = sx & 32'hFFFF;
    sy  = sy & 32'hFFFF;
    len = len & 32'hFFFF;
    if (len == 0)
      return;
    if (sx + len - 1 >= w)
      sx = (w - len - 1) & 32'hFFFF;
    if (sy >= h)
      sy = (h - 1) & 32'hFFFF;
    if (have_held)
      expected_spans.push_back(held_span);
    held_span.x     = sx[COORD_W-1:0];
    held_span.y     = sy[COORD_W-1:0];
    held_span.len   = len[LEN_W-1:0];
    held_span.color = color[COLOR_W-1:0];
    held_span.last  = 1'b0;
    have_held       = 1'b1;
  endfunction

  function automatic void predict_circle_spans(input int unsigned cx, input int unsigned cy,
                                               input int unsigned r, input int unsigned color);
    int unsigned row_max;
    int unsigned bound;
    int unsigned x;
    have_held = 1'b0;
    if (r == 0)
      return;
    row_max = (r * 707) / 1000 + 1;
    bound   = r * r + r / 2;
    x       = r;
    queue_span(cx - r, cy, 2 * r, color);
    for (int unsigned i = 1; i <= row_max; i++) begin
      if (i * i + x * x > bound) begin
        if (x > row_max) begin
          queue_span(cx - i + 1, cy + x, 2 * (i - 1), color);
          queue_span(cx - i + 1, cy - x, 2 * (i - 1), color);
        end
        if (x > 0)
          x--;
      end
      queue_span(cx - x, cy + i, 2 * x, color);
      queue_span(cx - x, cy - i, 2 * x, color);
    end
    if (have_held) begin
      held_span.last = 1'b1;
      expected_spans.push_back(held_span);
      have_held = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : watch
    span_t want;
    if (!rst_n) begin
      width_reg  = SCREEN_W'(DEF_SCREEN_WIDTH);
      height_reg = SCREEN_W'(DEF_SCREEN_HEIGHT);
      fail_count = 0;
      expected_spans.delete();
    end else begin
      if (out_strobe) begin
        if (expected_spans.size() == 0) begin
          report_mismatch("without expectation, x", out_span_x, 0);
        end else begin
          want = expected_spans.pop_front();
          if (out_span_x !== want.x)
            report_mismatch("x", out_span_x, want.x);
          if (out_span_y !== want.y)
            report_mismatch("y", out_span_y, want.y);
          if (out_span_length !== want.len)
            report_mismatch("length", out_span_length, want.len);
          if (out_span_color !== want.color)
            report_mismatch("color", out_span_color, want.color);
          if (out_last_span !== want.last)
            report_mismatch("last flag", out_last_span, want.last);
        end
      end
      if (start && !busy)
        predict_circle_spans(in_center_x, in_center_y, in_radius, in_color);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SCREEN_WIDTH)
          width_reg = pwdata[SCREEN_W-1:0];
        else
          height_reg = pwdata[SCREEN_W-1:0];
      end
    end
    spans_pending = expected_spans.size();
  end

endmodule

@@ verif/testbench.sv @@
module testbench;
  import fcsg_pkg::*;

  // Byte addresses of the two screen size registers
  localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_SCREEN_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_SCREEN_HEIGHT, 2'b00};
  // Cycles to let pass once idle, longer than a radius 15 circle keeps the block busy
  localparam int SETTLE_CYCLES = 60;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [COORD_W-1:0]    in_center_x;
  logic [COORD_W-1:0]    in_center_y;
  logic [RADIUS_W-1:0]   in_radius;
  logic [COLOR_W-1:0]    in_color;
  logic                  out_strobe;
  logic [COORD_W-1:0]    out_span_x;
  logic [COORD_W-1:0]    out_span_y;
  logic [LEN_W-1:0]      out_span_length;
  logic [COLOR_W-1:0]    out_span_color;
  logic                  out_last_span;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          fail_count;
  int          spans_pending;
  int unsigned cur_width;
  int unsigned cur_height;
  bit          gaps_on;

  filled_circle_span_generator_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_color        (in_color),
    .out_strobe      (out_strobe),
    .out_span_x      (out_span_x),
    .out_span_y      (out_span_y),
    .out_span_length (out_span_length),
    .out_span_color  (out_span_color),
    .out_last_span   (out_last_span),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // The checker watches both channels and the register port, predicts every
  // span of each accepted circle and compares; the top only drives stimulus.
  circle_span_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_color        (in_color),
    .out_strobe      (out_strobe),
    .out_span_x      (out_span_x),
    .out_span_y      (out_span_y),
    .out_span_length (out_span_length),
    .out_span_color  (out_span_color),
    .out_last_span   (out_last_span),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .spans_pending   (spans_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs or never drains its spans
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly short gaps, now and then one long enough to leave the block idle
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50)
      return 0;
    else if (p < 85)
      return $urandom_range(1, 3);
    else if (p < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 70);
  endfunction

  // Aim coordinates at the origin, the top of the 16-bit range, the screen
  // border, or anywhere at all
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned border);
    case ($urandom_range(0, 3))
      0:       return COORD_W'($urandom);
      1:       return COORD_W'($urandom_range(0, 20));
      2:       return COORD_W'($urandom_range(65515, 65535));
      default: return COORD_W'(border + 65516 + $urandom_range(0, 40));
    endcase
  endfunction

  // Present one circle command and hold it until the block takes it
  task automatic issue_circle(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                              input logic [RADIUS_W-1:0] r, input logic [COLOR_W-1:0] col);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      start       = 1'b0;
      // scramble the idle payload: it must be ignored
      in_center_x = COORD_W'($urandom);
      in_center_y = COORD_W'($urandom);
      in_radius   = RADIUS_W'($urandom);
      in_color    = COLOR_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       = 1'b1;
    in_center_x = cx;
    in_center_y = cy;
    in_radius   = r;
    in_color    = col;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_circle();
    logic [RADIUS_W-1:0] r;
    if ($urandom_range(0, 99) < 10)
      r = $urandom_range(0, 1) ? RADIUS_W'(0) : RADIUS_W'(15);
    else
      r = RADIUS_W'($urandom_range(1, 15));
    issue_circle(pick_coord(cur_width), pick_coord(cur_height), r, COLOR_W'($urandom));
  endtask

  // Drain the block, let it settle, then run one register write transaction
  task automatic write_screen_reg(input logic [APB_ADDR_W-1:0] addr, input int unsigned value);
    @(negedge clk);
    start = 1'b0;
    do @(negedge clk); while (busy || spans_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    // junk in the upper bits must not reach the 12-bit register
    pwdata  = ($urandom & ~32'hFFF) | (value & 32'hFFF);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (addr == WIDTH_ADDR)
      cur_width = value & 32'hFFF;
    else
      cur_height = value & 32'hFFF;
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h);
    write_screen_reg(WIDTH_ADDR, w);
    write_screen_reg(HEIGHT_ADDR, h);
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    start       = 1'b0;
    in_center_x = '0;
    in_center_y = '0;
    in_radius   = '0;
    in_color    = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_n       = 1'b0;
    cur_width   = DEF_SCREEN_WIDTH;
    cur_height  = DEF_SCREEN_HEIGHT;
    gaps_on     = 1'b1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed commands on the reset screen size
    issue_circle(16'd160, 16'd240, 4'd0, 16'h1234);    // zero radius: no spans
    issue_circle(16'd160, 16'd240, 4'd1, 16'h0000);
    issue_circle(16'd160, 16'd240, 4'd15, 16'hFFFF);
    issue_circle(16'd0, 16'd0, 4'd15, 16'hA5A5);       // wrap below zero
    issue_circle(16'hFFFF, 16'hFFFF, 4'd15, 16'h5A5A); // wrap past the top
    issue_circle(16'd315, 16'd240, 4'd8, 16'h0F0F);    // right border
    issue_circle(16'd160, 16'd478, 4'd8, 16'hF0F0);    // bottom border
    issue_circle(16'd319, 16'd479, 4'd15, 16'h8001);   // bottom right corner
    for (int r = 2; r <= 14; r++)
      issue_circle(16'd100, 16'd100, RADIUS_W'(r), COLOR_W'($urandom));

    // Random phases, each behind a new screen size; extremes first
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin w = 4095; h = 4095; end
        1: begin w = 1;    h = 1;    end
        2: begin w = 0;    h = 0;    end  // zero size: every span clamps and wraps
        3: begin w = 24;   h = 16;   end
        4: begin w = 4095; h = 1;    end
        5: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
        default: begin w = $urandom_range(1, 4095); h = $urandom_range(1, 4095); end
      endcase
      set_screen(w, h);
      for (int k = 0; k < 55; k++) begin
        // switch idling off for some stretches of back-to-back commands
        if (k % 16 == 0)
          gaps_on = ($urandom_range(0, 3) != 0);
        random_circle();
      end
    end

    @(negedge clk);
    start = 1'b0;
    do @(negedge clk); while (busy || spans_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
